[rtl/rotary_encoder_with_button_macros.svh]
// Assertion macros shared by the rotary encoder RTL.
`ifndef ROTARY_ENCODER_WITH_BUTTON_MACROS_SVH
`define ROTARY_ENCODER_WITH_BUTTON_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rotary encoder: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rotary encoder: next-cycle check failed");

`endif

[rtl/rotenc_pkg.sv]
// Types and constants shared by the rotary encoder with push button.
`timescale 1ns / 1ps

package rotenc_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_RELEASED    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_HELD        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_RELEASED     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_RELEASED     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_HELD         = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_HELD         = 3'd6;

	// Register widths and reset values
	localparam int TICKS_W = 16;
	localparam int STEP_W  = 15;
	localparam int LIMIT_W = 32;

	localparam logic [TICKS_W-1:0]        LONG_PRESS_RESET = 16'd800;
	localparam logic [STEP_W-1:0]         STEP_RESET       = 15'd1;
	localparam logic signed [LIMIT_W-1:0] LIMIT_MIN_RESET  = 32'sh8000_0000;
	localparam logic signed [LIMIT_W-1:0] LIMIT_MAX_RESET  = 32'sh7FFF_FFFF;

	// Request kinds
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_EDGE = 1'b1;

	// Event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_CLICK = 2'd1;
	localparam logic [1:0] EV_LONG  = 2'd2;

	// Button state machine
	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_PRESSING = 2'd1,
		ST_LONG     = 2'd2,
		ST_ROTATED  = 2'd3
	} btn_state_t;

	// Input request
	typedef struct packed {
		logic mode;
		logic button_down;
		logic dir_cw;
	} in_item_t;

	// Result
	typedef struct packed {
		logic [1:0]                event_res;
		logic signed [LIMIT_W-1:0] count_released_out;
		logic signed [LIMIT_W-1:0] count_held_out;
		logic [1:0]                button_state_out;
	} out_item_t;

endpackage

[rtl/rotary_encoder_with_button.sv]
// Top level of the rotary encoder with push button: click, long press and two counters.
`timescale 1ns / 1ps
`include "rotary_encoder_with_button_macros.svh"

// Takes one request per cycle: a 1 ms tick (button level) or a channel-A rotation
// edge (button level and direction). Every request gives exactly one result: it is
// held in the input register, then the button state machine and one shared
// saturating/clamping counter update write the state registers and the result
// register in the same edge. Sustained rate is one request per clock; a stall on the
// result side holds the result register and then the input register. The result
// carries the event of this request (none, click or long press, as a one-result
// pulse), both counters after the request (low 32 bits) and the button state. The
// user must write registers through cfg_we/cfg_index/cfg_wdata only while no request
// is in flight; the block does not enforce this. Unknown indexes are ignored.
module rotary_encoder_with_button import rotenc_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  in_item_t               item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output out_item_t              result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int SW = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	// Configuration registers
	logic [TICKS_W-1:0]        long_press_ticks_q;
	logic [STEP_W-1:0]         step_released_q;
	logic [STEP_W-1:0]         step_held_q;
	logic signed [LIMIT_W-1:0] min_released_q;
	logic signed [LIMIT_W-1:0] max_released_q;
	logic signed [LIMIT_W-1:0] min_held_q;
	logic signed [LIMIT_W-1:0] max_held_q;

	// Pipeline
	logic      item_valid_s1;
	in_item_t  item_s1;
	logic      result_valid_s2;
	out_item_t result_s2;
	logic      item_take;
	logic      advance;

	// Block state
	btn_state_t           button_state_q;
	btn_state_t           button_state_d;
	logic [TICKS_W-1:0]   press_ticks_q;
	logic [TICKS_W-1:0]   press_ticks_d;
	logic [TICKS_W-1:0]   press_inc;
	logic                 long_hit;
	logic                 rotated_q;
	logic                 rotated_d;
	logic [1:0]           event_d;
	logic signed [SW-1:0] count_released_q;
	logic signed [SW-1:0] count_held_q;
	logic signed [SW-1:0] count_released_d;
	logic signed [SW-1:0] count_held_d;

	// Shared counter update
	logic                      edge_req;
	logic                      sel_held;
	logic signed [SW-1:0]      count_sel;
	logic [STEP_W-1:0]         step_sel;
	logic signed [LIMIT_W-1:0] lo_sel;
	logic signed [LIMIT_W-1:0] hi_sel;
	logic signed [SW-1:0]      count_moved;
	logic                      upd_held;
	logic                      upd_released;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ticks_q <= LONG_PRESS_RESET;
			step_released_q    <= STEP_RESET;
			step_held_q        <= STEP_RESET;
			min_released_q     <= LIMIT_MIN_RESET;
			max_released_q     <= LIMIT_MAX_RESET;
			min_held_q         <= LIMIT_MIN_RESET;
			max_held_q         <= LIMIT_MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg_wdata[TICKS_W-1:0];
				REG_STEP_RELEASED:    step_released_q    <= cfg_wdata[STEP_W-1:0];
				REG_STEP_HELD:        step_held_q        <= cfg_wdata[STEP_W-1:0];
				REG_MIN_RELEASED:     min_released_q     <= cfg_wdata[LIMIT_W-1:0];
				REG_MAX_RELEASED:     max_released_q     <= cfg_wdata[LIMIT_W-1:0];
				REG_MIN_HELD:         min_held_q         <= cfg_wdata[LIMIT_W-1:0];
				REG_MAX_HELD:         max_held_q         <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on whenever the result register is free or draining
	assign advance    = item_valid_s1 && (!result_valid_s2 || !result_stall);
	assign item_stall = item_valid_s1 && !advance;
	assign item_take  = item_valid && !item_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_take) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
	end

	// Press counter helpers
	assign edge_req  = (item_s1.mode == MODE_EDGE);
	assign press_inc = (press_ticks_q == {TICKS_W{1'b1}}) ? press_ticks_q
		: press_ticks_q + TICKS_W'(1);
	assign long_hit  = (press_inc >= long_press_ticks_q);

	// Button state machine: next state
	always_comb begin
		button_state_d = button_state_q;
		press_ticks_d  = press_ticks_q;
		rotated_d      = rotated_q;
		if (edge_req) begin
			if (item_s1.button_down) begin
				rotated_d      = 1'b1;
				button_state_d = ST_ROTATED;
			end
		end else begin
			unique case (button_state_q)
				ST_IDLE: begin
					if (item_s1.button_down) begin
						button_state_d = ST_PRESSING;
						press_ticks_d  = '0;
						rotated_d      = 1'b0;
					end
				end
				ST_PRESSING: begin
					if (!item_s1.button_down) begin
						button_state_d = ST_IDLE;
					end else begin
						press_ticks_d = press_inc;
						if (long_hit) begin
							button_state_d = ST_LONG;
						end
					end
				end
				ST_LONG, ST_ROTATED: begin
					if (!item_s1.button_down) begin
						button_state_d = ST_IDLE;
					end
				end
			endcase
		end
	end

	// Button state machine: event output
	always_comb begin
		event_d = EV_NONE;
		if (!edge_req && button_state_q == ST_PRESSING) begin
			if (!item_s1.button_down) begin
				if (!rotated_q) begin
					event_d = EV_CLICK;
				end
			end else if (long_hit) begin
				event_d = EV_LONG;
			end
		end
	end

	// One counter moves per edge request; the button level picks which
	assign sel_held     = item_s1.button_down;
	assign count_sel    = sel_held ? count_held_q : count_released_q;
	assign step_sel     = sel_held ? step_held_q : step_released_q;
	assign lo_sel       = sel_held ? min_held_q : min_released_q;
	assign hi_sel       = sel_held ? max_held_q : max_released_q;
	assign upd_held     = advance && edge_req && sel_held;
	assign upd_released = advance && edge_req && !sel_held;

	rotenc_move #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_move (
		.count      (count_sel),
		.step       (step_sel),
		.up         (item_s1.dir_cw),
		.lo         (lo_sel),
		.hi         (hi_sel),
		.count_next (count_moved)
	);

	assign count_held_d     = upd_held ? count_moved : count_held_q;
	assign count_released_d = upd_released ? count_moved : count_released_q;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_state_q   <= ST_IDLE;
			press_ticks_q    <= '0;
			rotated_q        <= 1'b0;
			count_released_q <= '0;
			count_held_q     <= '0;
		end else if (advance) begin
			button_state_q   <= button_state_d;
			press_ticks_q    <= press_ticks_d;
			rotated_q        <= rotated_d;
			count_released_q <= count_released_d;
			count_held_q     <= count_held_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.event_res          <= event_d;
			result_s2.count_released_out <= count_released_d[LIMIT_W-1:0];
			result_s2.count_held_out     <= count_held_d[LIMIT_W-1:0];
			result_s2.button_state_out   <= button_state_d;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	// Checks
	`RE_ASSERT_NEXT(a_long_enters_long, advance && event_d == EV_LONG, button_state_q == ST_LONG)
	`RE_ASSERT_NOW(a_click_not_rotated, advance && event_d == EV_CLICK, !rotated_q && button_state_q == ST_PRESSING)
	`RE_ASSERT_NEXT(a_held_count_quiet, !upd_held, $stable(count_held_q))
	`RE_ASSERT_NEXT(a_released_count_quiet, !upd_released, $stable(count_released_q))
	`RE_ASSERT_NOW(a_stall_when_busy, item_stall, item_valid_s1 && result_valid_s2 && result_stall)

endmodule

[rtl/rotenc_move.sv]
// Saturating step of one position counter followed by its max and min clamps.
`timescale 1ns / 1ps

module rotenc_move import rotenc_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic signed [((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W)-1:0] count,
	input  logic [STEP_W-1:0]                                                step,
	input  logic                                                             up,
	input  logic signed [LIMIT_W-1:0]                                        lo,
	input  logic signed [LIMIT_W-1:0]                                        hi,
	output logic signed [((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W)-1:0] count_next
);

	// Storage width covers both the counter range and any clamp value;
	// two guard bits keep the add/subtract exact.
	localparam int SW = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
	localparam int AW = SW + 2;

	localparam logic signed [AW-1:0] CntMax =
		{{(AW-COUNT_WIDTH+1){1'b0}}, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [AW-1:0] CntMin = ~CntMax;

	logic signed [AW-1:0] count_ext;
	logic signed [AW-1:0] step_ext;
	logic signed [AW-1:0] lo_ext;
	logic signed [AW-1:0] hi_ext;
	logic signed [AW-1:0] sum;
	logic signed [AW-1:0] sat;
	logic signed [AW-1:0] capped;
	logic signed [AW-1:0] clamped;

	assign count_ext = {{2{count[SW-1]}}, count};
	assign step_ext  = {{(AW-STEP_W){1'b0}}, step};
	assign lo_ext    = {{(AW-LIMIT_W){lo[LIMIT_W-1]}}, lo};
	assign hi_ext    = {{(AW-LIMIT_W){hi[LIMIT_W-1]}}, hi};

	// Step, saturated at the counter's signed range
	always_comb begin
		if (up) begin
			sum = count_ext + step_ext;
			sat = (sum > CntMax) ? CntMax : sum;
		end else begin
			sum = count_ext - step_ext;
			sat = (sum < CntMin) ? CntMin : sum;
		end
	end

	// Max clamp first, then min: min wins when the limits cross
	assign capped  = (sat > hi_ext) ? hi_ext : sat;
	assign clamped = (capped < lo_ext) ? lo_ext : capped;

	assign count_next = clamped[SW-1:0];

endmodule

[sim/tb.sv]
// Self-checking testbench for the rotary encoder with push button block.
`timescale 1ns / 1ps

module tb;
	import rotenc_pkg::*;

	localparam int CW = 32;
	localparam longint CNT_MAX = (longint'(1) <<< (CW - 1)) - 1;
	localparam longint CNT_MIN = -CNT_MAX - 1;
	// index with no register behind it
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	in_item_t               item;
	logic                   result_valid;
	logic                   result_stall;
	out_item_t              result;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	rotary_encoder_with_button #(.COUNT_WIDTH(CW)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the registers and the button/counter state
	logic [TICKS_W-1:0] long_ticks;
	logic [STEP_W-1:0]  step_rel;
	logic [STEP_W-1:0]  step_hld;
	longint             min_rel, max_rel, min_hld, max_hld;
	btn_state_t         btn;
	logic [15:0]        hold_ticks;
	logic               turned_while_held;
	longint             cnt_rel, cnt_hld;

	out_item_t knob_results_q[$];
	out_item_t want_res;

	int errors = 0;
	int checked = 0;
	int requests = 0;
	int clicks = 0;
	int long_presses = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	bit calm = 1'b0;

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up if the run hangs
	initial begin
		#(50_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result side back-pressure in random bursts
	initial begin : stall_gen
		int hold;
		hold = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!calm && stalls_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 10);
			end
			result_stall <= (hold > 0);
		end
	end

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= 40) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (knob_results_q.size() == 0) begin
				report_mismatch("result arrived with no request pending");
			end else begin
				want_res = knob_results_q.pop_front();
				checked++;
				if (result.event_res !== want_res.event_res) begin
					report_mismatch($sformatf("event got %0d want %0d",
						result.event_res, want_res.event_res));
				end
				if (result.count_released_out !== want_res.count_released_out) begin
					report_mismatch($sformatf("released count got %0d want %0d",
						result.count_released_out, want_res.count_released_out));
				end
				if (result.count_held_out !== want_res.count_held_out) begin
					report_mismatch($sformatf("held count got %0d want %0d",
						result.count_held_out, want_res.count_held_out));
				end
				if (result.button_state_out !== want_res.button_state_out) begin
					report_mismatch($sformatf("button state got %0d want %0d",
						result.button_state_out, want_res.button_state_out));
				end
			end
		end
	end

	task automatic reset_model();
		long_ticks = LONG_PRESS_RESET;
		step_rel = STEP_RESET;
		step_hld = STEP_RESET;
		min_rel = longint'(LIMIT_MIN_RESET);
		max_rel = longint'(LIMIT_MAX_RESET);
		min_hld = longint'(LIMIT_MIN_RESET);
		max_hld = longint'(LIMIT_MAX_RESET);
		btn = ST_IDLE;
		hold_ticks = '0;
		turned_while_held = 1'b0;
		cnt_rel = 0;
		cnt_hld = 0;
	endtask

	// Saturating step, then max clamp, then min clamp (min wins if min > max)
	function automatic longint move_count(longint c, longint stp, bit up,
			longint lo, longint hi);
		if (up) begin
			c = (c > CNT_MAX - stp) ? CNT_MAX : c + stp;
		end else begin
			c = (c < CNT_MIN + stp) ? CNT_MIN : c - stp;
		end
		if (c > hi) c = hi;
		if (c < lo) c = lo;
		return c;
	endfunction

	function automatic out_item_t predict_knob_result(in_item_t r);
		out_item_t o;
		logic [1:0] ev;
		ev = EV_NONE;
		if (r.mode == MODE_EDGE) begin
			if (r.button_down) begin
				// turning with the button down always forces rotated
				turned_while_held = 1'b1;
				btn = ST_ROTATED;
				cnt_hld = move_count(cnt_hld, longint'(step_hld), r.dir_cw, min_hld, max_hld);
			end else begin
				cnt_rel = move_count(cnt_rel, longint'(step_rel), r.dir_cw, min_rel, max_rel);
			end
		end else begin
			case (btn)
				ST_IDLE: begin
					if (r.button_down) begin
						btn = ST_PRESSING;
						hold_ticks = '0;
						turned_while_held = 1'b0;
					end
				end
				ST_PRESSING: begin
					if (!r.button_down) begin
						if (!turned_while_held) ev = EV_CLICK;
						btn = ST_IDLE;
					end else begin
						if (hold_ticks != 16'hFFFF) hold_ticks = hold_ticks + 16'd1;
						if (hold_ticks >= long_ticks) begin
							btn = ST_LONG;
							ev = EV_LONG;
						end
					end
				end
				default: begin
					if (!r.button_down) btn = ST_IDLE;
				end
			endcase
		end
		o.event_res = ev;
		o.count_released_out = cnt_rel[31:0];
		o.count_held_out = cnt_hld[31:0];
		o.button_state_out = btn;
		return o;
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
		case (idx)
			REG_LONG_PRESS_TICKS: long_ticks = d[TICKS_W-1:0];
			REG_STEP_RELEASED:    step_rel = d[STEP_W-1:0];
			REG_STEP_HELD:        step_hld = d[STEP_W-1:0];
			REG_MIN_RELEASED:     min_rel = longint'($signed(d));
			REG_MAX_RELEASED:     max_rel = longint'($signed(d));
			REG_MIN_HELD:         min_hld = longint'($signed(d));
			REG_MAX_HELD:         max_hld = longint'($signed(d));
			default: ;
		endcase
	endfunction

	// One request: optional idle burst, then hold until taken
	task automatic send_req(in_item_t r);
		int n;
		out_item_t o;
		if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 10);
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= r;
		while (1) begin
			@(posedge clk);
			if (!item_stall) break;
		end
		o = predict_knob_result(r);
		knob_results_q.push_back(o);
		requests++;
		if (o.event_res == EV_CLICK) clicks++;
		if (o.event_res == EV_LONG) long_presses++;
	endtask

	task automatic tick(bit down);
		in_item_t r;
		r.mode = MODE_TICK;
		r.button_down = down;
		r.dir_cw = 1'($urandom_range(0, 1));
		send_req(r);
	endtask

	task automatic turn(bit held, bit cw);
		in_item_t r;
		r.mode = MODE_EDGE;
		r.button_down = held;
		r.dir_cw = cw;
		send_req(r);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain_pipeline();
		@(negedge clk);
		item_valid <= 1'b0;
		while (knob_results_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		apply_reg(idx, d);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] clip32(longint v);
		if (v > CNT_MAX) v = CNT_MAX;
		if (v < CNT_MIN) v = CNT_MIN;
		return v[31:0];
	endfunction

	// Step register value with random junk above the 15 used bits
	function automatic logic [31:0] pick_step();
		logic [31:0] d;
		d = $urandom();
		case ($urandom_range(0, 5))
			0: d[STEP_W-1:0] = '0;
			1: d[STEP_W-1:0] = '1;
			2: d[STEP_W-1:0] = STEP_W'($urandom_range(1, 32767));
			default: d[STEP_W-1:0] = STEP_W'($urandom_range(1, 20));
		endcase
		return d;
	endfunction

	task automatic pick_limits(longint cur, output logic [31:0] lo, output logic [31:0] hi);
		case ($urandom_range(0, 5))
			0: begin
				lo = LIMIT_MIN_RESET;
				hi = LIMIT_MAX_RESET;
			end
			1: begin
				// inverted window
				lo = clip32(cur + longint'($urandom_range(1, 50)));
				hi = clip32(cur - longint'($urandom_range(0, 50)));
			end
			2: begin
				lo = clip32(CNT_MAX - 200);
				hi = LIMIT_MAX_RESET;
			end
			3: begin
				lo = LIMIT_MIN_RESET;
				hi = clip32(CNT_MIN + 200);
			end
			default: begin
				lo = clip32(cur - longint'($urandom_range(0, 100)));
				hi = clip32(cur + longint'($urandom_range(0, 100)));
			end
		endcase
	endtask

	task automatic randomize_config();
		logic [31:0] lo, hi;
		case ($urandom_range(0, 9))
			0: write_reg(REG_LONG_PRESS_TICKS, 32'd0);
			1: write_reg(REG_LONG_PRESS_TICKS, 32'hFFFF);
			default: write_reg(REG_LONG_PRESS_TICKS, $urandom_range(1, 12));
		endcase
		write_reg(REG_STEP_RELEASED, pick_step());
		write_reg(REG_STEP_HELD, pick_step());
		pick_limits(cnt_rel, lo, hi);
		write_reg(REG_MIN_RELEASED, lo);
		write_reg(REG_MAX_RELEASED, hi);
		pick_limits(cnt_hld, lo, hi);
		write_reg(REG_MIN_HELD, lo);
		write_reg(REG_MAX_HELD, hi);
	endtask

	// Reset values: released turns, tick direction ignored, held turn from idle
	task automatic test_reset_defaults();
		tick(1'b0);
		turn(1'b0, 1'b1);
		turn(1'b0, 1'b0);
		turn(1'b1, 1'b0);
		tick(1'b1);
		tick(1'b0);
	endtask

	// Plain click, and a press spoiled by turning the knob
	task automatic test_click();
		tick(1'b1);
		tick(1'b1);
		tick(1'b0);
		tick(1'b1);
		turn(1'b1, 1'b1);
		tick(1'b0);
	endtask

	// Long press at a short length and at zero length, and a short press at the longest length
	task automatic test_long_press();
		drain_pipeline();
		write_reg(REG_LONG_PRESS_TICKS, 32'd3);
		repeat (4) tick(1'b1);
		tick(1'b0);
		drain_pipeline();
		write_reg(REG_LONG_PRESS_TICKS, 32'd0);
		tick(1'b1);
		tick(1'b1);
		tick(1'b0);
		drain_pipeline();
		write_reg(REG_LONG_PRESS_TICKS, 32'hFFFF);
		tick(1'b1);
		tick(1'b1);
		tick(1'b0);
	endtask

	// Saturation at both ends, inverted window, zero step, unused index
	task automatic test_counter_limits();
		drain_pipeline();
		write_reg(REG_STEP_RELEASED, 32'hFFFF_FFFF);
		write_reg(REG_MIN_RELEASED, 32'h7FFF_FFF0);
		turn(1'b0, 1'b1);
		drain_pipeline();
		write_reg(REG_MIN_RELEASED, LIMIT_MIN_RESET);
		turn(1'b0, 1'b1);
		turn(1'b0, 1'b0);
		drain_pipeline();
		write_reg(REG_STEP_HELD, 32'h0000_7FFF);
		write_reg(REG_MAX_HELD, 32'h8000_0010);
		turn(1'b1, 1'b0);
		drain_pipeline();
		write_reg(REG_MAX_HELD, LIMIT_MAX_RESET);
		turn(1'b1, 1'b0);
		drain_pipeline();
		write_reg(REG_MIN_RELEASED, 32'd100);
		write_reg(REG_MAX_RELEASED, 32'd50);
		write_reg(REG_STEP_HELD, 32'hFFFF_8000);
		write_reg(REG_UNUSED, $urandom());
		turn(1'b0, 1'b0);
		turn(1'b1, 1'b1);
		tick(1'b0);
	endtask

	// Random phase: mostly press gestures and released turns, some noise
	task automatic test_random_phase(int target, bit last);
		int sent;
		int n;
		int lim;
		logic [2:0] raw;
		drain_pipeline();
		randomize_config();
		calm = last;
		gaps_on = ($urandom_range(0, 3) != 0);
		stalls_on = ($urandom_range(0, 3) != 0);
		sent = 0;
		while (sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					lim = (long_ticks > 12) ? 14 : int'(long_ticks) + 2;
					n = $urandom_range(0, lim);
					tick(1'b1);
					repeat (n) begin
						if ($urandom_range(0, 5) == 0) turn(1'b1, 1'($urandom_range(0, 1)));
						else tick(1'b1);
					end
					tick(1'b0);
					sent += n + 2;
				end
				5, 6, 7: begin
					n = $urandom_range(1, 8);
					repeat (n) begin
						if ($urandom_range(0, 4) == 0) tick(1'b0);
						else turn(1'b0, 1'($urandom_range(0, 1)));
					end
					sent += n;
				end
				default: begin
					n = $urandom_range(1, 6);
					repeat (n) begin
						raw = 3'($urandom_range(0, 7));
						send_req(in_item_t'(raw));
					end
					sent += n;
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		reset_model();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_click();
		test_long_press();
		test_counter_limits();
		for (int p = 0; p < 8; p++) begin
			test_random_phase(100, p == 7);
		end

		drain_pipeline();
		repeat (10) @(posedge clk);
		$display("Sent %0d requests (ticks and turns, held and released): directed cases, then 8 random register setups",
			requests);
		$display("Checked %0d results, %0d clicks and %0d long presses among them",
			checked, clicks, long_presses);
		if (errors == 0 && knob_results_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
